// ===== rtl/icg_pkg.sv =====
// Shared types and constants for the inversive congruential generator.
package icg_pkg;

    localparam int VAL_W = 31;
    localparam int CNT_W = $clog2(VAL_W);
    localparam int IDX_W = 2;

    typedef logic [VAL_W-1:0] val_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t BIT_TOP = CNT_W'(VAL_W - 1);

    typedef enum logic [IDX_W-1:0] {
        CFG_MODULUS    = 2'd0,
        CFG_MULTIPLIER = 2'd1,
        CFG_INCREMENT  = 2'd2,
        CFG_SEED       = 2'd3
    } cfg_idx_t;

    localparam val_t MODULUS_RST    = 31'h7FFF_FFFF;
    localparam val_t MULTIPLIER_RST = 31'd1;
    localparam val_t INCREMENT_RST  = 31'd0;
    localparam val_t SEED_RST       = 31'd1;

    typedef struct packed {
        val_t modulus;
        val_t multiplier;
        val_t increment;
        val_t seed;
    } icg_cfg_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        logic    cin;
    } alu_ctl_t;

endpackage

// ===== rtl/icg_alu.sv =====
// Shared modular add/subtract unit: one add and one conditional correction.
module icg_alu
    import icg_pkg::*;
(
    input  alu_ctl_t ctl,
    input  val_t     x,
    input  val_t     y,
    input  val_t     d,
    output val_t     res,
    output logic     ge
);

    logic [VAL_W+1:0] sum;
    logic [VAL_W+1:0] sum_red;
    logic [VAL_W:0]   diff;
    logic [VAL_W:0]   diff_fix;
    logic             borrow;

    // add: x + y + cin, minus d when not below d (sum < 2d assumed)
    // sub: x - y, plus d when negative
    always_comb
    begin
        sum      = {2'b00, x} + {2'b00, y} + {{(VAL_W+1){1'b0}}, ctl.cin};
        ge       = (sum >= {2'b00, d});
        sum_red  = ge ? (sum - {2'b00, d}) : sum;
        diff     = {1'b0, x} - {1'b0, y};
        borrow   = diff[VAL_W];
        diff_fix = borrow ? (diff + {1'b0, d}) : diff;
        case (ctl.op)
            ALU_ADD: res = sum_red[VAL_W-1:0];
            ALU_SUB: res = diff_fix[VAL_W-1:0];
            default: res = sum_red[VAL_W-1:0];
        endcase
    end

endmodule

// ===== rtl/icg_engine.sv =====
// Sequencer and datapath: reduction, extended Euclid, modular multiply and increment.
module icg_engine
    import icg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  icg_cfg_t cfg,
    input  logic     req_valid,
    output logic     req_ready,
    input  logic     restart,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output val_t     value,
    output logic     error
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_RED   = 12'b0000_0000_0010,
        ST_EUC   = 12'b0000_0000_0100,
        ST_DIV_A = 12'b0000_0000_1000,
        ST_DIV_B = 12'b0000_0001_0000,
        ST_DIV_C = 12'b0000_0010_0000,
        ST_DIV_T = 12'b0000_0100_0000,
        ST_MUL_A = 12'b0000_1000_0000,
        ST_MUL_B = 12'b0001_0000_0000,
        ST_INC   = 12'b0010_0000_0000,
        ST_FIN   = 12'b0100_0000_0000,
        ST_OUT   = 12'b1000_0000_0000
    } state_t;

    state_t   state_reg, state_next;
    cnt_t     cnt_reg, cnt_next;
    val_t     cur_reg, cur_next;
    logic     seed_pending_reg, seed_pending_next;
    logic     halted_reg, halted_next;
    val_t     r0_reg, r0_next;
    val_t     r1_reg, r1_next;
    val_t     t0_reg, t0_next;
    val_t     t1_reg, t1_next;
    val_t     rem_reg, rem_next;
    val_t     acc_reg, acc_next;
    logic     q_reg, q_next;
    val_t     value_reg, value_next;
    logic     error_reg, error_next;

    alu_ctl_t alu_ctl;
    val_t     alu_x;
    val_t     alu_y;
    val_t     alu_d;
    val_t     alu_res;
    logic     alu_ge;

    icg_alu u_alu (
        .ctl (alu_ctl),
        .x   (alu_x),
        .y   (alu_y),
        .d   (alu_d),
        .res (alu_res),
        .ge  (alu_ge)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_OUT);
    assign value     = value_reg;
    assign error     = error_reg;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        cur_next          = cur_reg;
        seed_pending_next = seed_pending_reg;
        halted_next       = halted_reg;
        r0_next           = r0_reg;
        r1_next           = r1_reg;
        t0_next           = t0_reg;
        t1_next           = t1_reg;
        rem_next          = rem_reg;
        acc_next          = acc_reg;
        q_next            = q_reg;
        value_next        = value_reg;
        error_next        = error_reg;
        alu_ctl.op        = ALU_ADD;
        alu_ctl.cin       = 1'b0;
        alu_x             = rem_reg;
        alu_y             = rem_reg;
        alu_d             = cfg.modulus;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (restart || (seed_pending_reg && !halted_reg))
                    begin
                        halted_next       = 1'b0;
                        seed_pending_next = 1'b0;
                        cur_next          = cfg.seed;
                        value_next        = cfg.seed;
                        error_next        = 1'b0;
                        state_next        = ST_OUT;
                    end
                    else if (halted_reg)
                    begin
                        value_next = '0;
                        error_next = 1'b1;
                        state_next = ST_OUT;
                    end
                    else if (cfg.modulus < VAL_W'(2))
                    begin
                        halted_next = 1'b1;
                        value_next  = '0;
                        error_next  = 1'b1;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        rem_next   = '0;
                        cnt_next   = BIT_TOP;
                        state_next = ST_RED;
                    end
                end
            end

            // previous value mod modulus, one bit per cycle
            ST_RED:
            begin
                alu_ctl.cin = cur_reg[cnt_reg];
                rem_next    = alu_res;
                if (cnt_reg == '0)
                begin
                    r0_next    = cfg.modulus;
                    r1_next    = alu_res;
                    t0_next    = '0;
                    t1_next    = VAL_W'(1);
                    state_next = ST_EUC;
                end
                else
                begin
                    cnt_next = cnt_reg - cnt_t'(1);
                end
            end

            ST_EUC:
            begin
                if (r1_reg == '0)
                begin
                    if (r0_reg == VAL_W'(1))
                    begin
                        acc_next   = '0;
                        cnt_next   = BIT_TOP;
                        state_next = ST_MUL_A;
                    end
                    else
                    begin
                        halted_next = 1'b1;
                        value_next  = '0;
                        error_next  = 1'b1;
                        state_next  = ST_OUT;
                    end
                end
                else
                begin
                    rem_next   = '0;
                    acc_next   = '0;
                    cnt_next   = BIT_TOP;
                    state_next = ST_DIV_A;
                end
            end

            // quotient bit of r0 / r1
            ST_DIV_A:
            begin
                alu_ctl.cin = r0_reg[cnt_reg];
                alu_d       = r1_reg;
                rem_next    = alu_res;
                q_next      = alu_ge;
                if (acc_reg != '0)
                begin
                    state_next = ST_DIV_B;
                end
                else if (alu_ge)
                begin
                    state_next = ST_DIV_C;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = ST_DIV_T;
                end
                else
                begin
                    cnt_next   = cnt_reg - cnt_t'(1);
                    state_next = ST_DIV_A;
                end
            end

            // q * t1 mod modulus, Horner form: double
            ST_DIV_B:
            begin
                alu_x    = acc_reg;
                alu_y    = acc_reg;
                acc_next = alu_res;
                if (q_reg)
                begin
                    state_next = ST_DIV_C;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = ST_DIV_T;
                end
                else
                begin
                    cnt_next   = cnt_reg - cnt_t'(1);
                    state_next = ST_DIV_A;
                end
            end

            // add t1
            ST_DIV_C:
            begin
                alu_x    = acc_reg;
                alu_y    = t1_reg;
                acc_next = alu_res;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DIV_T;
                end
                else
                begin
                    cnt_next   = cnt_reg - cnt_t'(1);
                    state_next = ST_DIV_A;
                end
            end

            ST_DIV_T:
            begin
                alu_ctl.op = ALU_SUB;
                alu_x      = t0_reg;
                alu_y      = acc_reg;
                t1_next    = alu_res;
                t0_next    = t1_reg;
                r0_next    = r1_reg;
                r1_next    = rem_reg;
                state_next = ST_EUC;
            end

            // inverse * multiplier mod modulus, multiplier bits MSB first
            ST_MUL_A:
            begin
                alu_x    = acc_reg;
                alu_y    = acc_reg;
                acc_next = alu_res;
                if (cfg.multiplier[cnt_reg])
                begin
                    state_next = ST_MUL_B;
                end
                else if (cnt_reg == '0)
                begin
                    rem_next   = '0;
                    cnt_next   = BIT_TOP;
                    state_next = ST_INC;
                end
                else
                begin
                    cnt_next   = cnt_reg - cnt_t'(1);
                    state_next = ST_MUL_A;
                end
            end

            ST_MUL_B:
            begin
                alu_x    = acc_reg;
                alu_y    = t0_reg;
                acc_next = alu_res;
                if (cnt_reg == '0)
                begin
                    rem_next   = '0;
                    cnt_next   = BIT_TOP;
                    state_next = ST_INC;
                end
                else
                begin
                    cnt_next   = cnt_reg - cnt_t'(1);
                    state_next = ST_MUL_A;
                end
            end

            // increment mod modulus
            ST_INC:
            begin
                alu_ctl.cin = cfg.increment[cnt_reg];
                rem_next    = alu_res;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - cnt_t'(1);
                end
            end

            ST_FIN:
            begin
                alu_x      = acc_reg;
                alu_y      = rem_reg;
                cur_next   = alu_res;
                value_next = alu_res;
                error_next = 1'b0;
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            cur_reg          <= '0;
            seed_pending_reg <= 1'b1;
            halted_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            cur_reg          <= cur_next;
            seed_pending_reg <= seed_pending_next;
            halted_reg       <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        rem_reg   <= rem_next;
        acc_reg   <= acc_next;
        q_reg     <= q_next;
        value_reg <= value_next;
        error_reg <= error_next;
    end

endmodule

// ===== rtl/inversive_congruential_generator_core.sv =====
// Top level of the inversive congruential generator: configuration registers and engine.
//
// Request channel (req_valid/req_ready, restart): each transfer asks for one value.
// restart=1, or the first request after reset, returns the seed register as is.
// Otherwise the block returns (multiplier * inverse(previous) + increment) mod modulus.
// Response channel (rsp_valid/rsp_ready, value, error): one transfer per request.
// When no inverse exists, error=1 and value=0, and the block stays halted
// (every request answers error) until a request with restart=1.
// Seed or halted answers are valid in the cycle after the request transfer.
// A full value takes a bit-serial reduction of the previous value, then Euclid
// steps, each a bit-serial division (one quotient bit at a time on the shared
// modular adder), at most about 45 steps, then a bit-serial modular multiply,
// the bit-serial increment, a final addition and the output state.
// One request is in flight at a time; req_ready is high only when idle.
// The response is held in an output register until rsp_ready; a stalled
// receiver keeps the block busy and req_ready low.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// the user must write it only while idle, which the block does not enforce.
// Reset restores register defaults and makes the next request return the seed.
module inversive_congruential_generator_core
    import icg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  val_t             cfg_data,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic             restart,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output val_t             value,
    output logic             error
);

    icg_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modulus    <= MODULUS_RST;
            cfg_reg.multiplier <= MULTIPLIER_RST;
            cfg_reg.increment  <= INCREMENT_RST;
            cfg_reg.seed       <= SEED_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MODULUS:    cfg_reg.modulus    <= cfg_data;
                CFG_MULTIPLIER: cfg_reg.multiplier <= cfg_data;
                CFG_INCREMENT:  cfg_reg.increment  <= cfg_data;
                CFG_SEED:       cfg_reg.seed       <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    icg_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .restart   (restart),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .value     (value),
        .error     (error)
    );

endmodule
